[hw/rtl/longest_match_text_substituter_core_defines.svh]
// Assertion macros for the longest-match substituter checker.
`ifndef LONGEST_MATCH_TEXT_SUBSTITUTER_CORE_DEFINES_SVH
`define LONGEST_MATCH_TEXT_SUBSTITUTER_CORE_DEFINES_SVH

// Implication check under active-low synchronous reset.
`define LMTS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define LMTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lmts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types and codes for the longest-match substituter.
// ----------------------------------------------------------------------------
package lmts_pkg;

    localparam logic OP_TEXT  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_byte;    // append s_ byte to window
        logic write_rule;   // store rule slot
        logic scan_clear;   // start a new match scan
        logic scan_step;    // evaluate one slot
        logic resolve;      // latch winner, start emitting
        logic emit_step;    // advance emit index (output taken)
        logic finish;       // consume matched bytes from window
    } lmts_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;    // last slot evaluated
        logic emit_done;    // current output byte is last of position
        logic emit_none;    // position emits no bytes
        logic window_full;
        logic window_empty;
    } lmts_stat_t;

endpackage

[hw/rtl/lmts_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_datapath
// Rule table, lookahead window, slot-serial matcher and emit index.
// ----------------------------------------------------------------------------
module lmts_datapath #(
    parameter int RULE_SLOTS = 16,
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lmts_pkg::lmts_cmd_t cmd,
    output lmts_pkg::lmts_stat_t stat,
    input  logic [7:0]          in_byte,
    input  logic [3:0]          in_slot,
    input  logic [63:0]         in_pattern,
    input  logic [3:0]          in_pattern_len,
    input  logic [63:0]         in_replacement,
    input  logic [3:0]          in_replacement_len,
    output logic [7:0]          out_byte
);
    import lmts_pkg::*;

    localparam int SW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int WW = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WI = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int PB = 8 * MAX_PATTERN_BYTES;
    localparam int RB = 8 * MAX_REPLACEMENT_BYTES;
    localparam int RW = $clog2(MAX_REPLACEMENT_BYTES + 1);
    localparam int EI = (MAX_REPLACEMENT_BYTES > 1) ? $clog2(MAX_REPLACEMENT_BYTES) : 1;

    // Rule table in flops (small, read at one scanned slot index)
    logic [PB-1:0] pat_reg [RULE_SLOTS];
    logic [WW-1:0] plen_reg [RULE_SLOTS];
    logic [RB-1:0] rep_reg [RULE_SLOTS];
    logic [RW-1:0] rlen_reg [RULE_SLOTS];

    logic [7:0]    win_reg [MAX_PATTERN_BYTES];
    logic [WW-1:0] fill_reg, fill_next;
    logic [SW:0]   scan_reg;
    logic [WW-1:0] best_len_reg;
    logic [RB-1:0] best_rep_reg;
    logic [RW-1:0] best_rlen_reg;
    logic [7:0]    head_reg;
    logic          hit_reg;
    logic [RW-1:0] emit_reg;
    logic [WW-1:0] cons;
    logic [SW-1:0] wslot;

    logic [WW-1:0] pl_sat;
    logic [RW-1:0] rl_sat;
    always_comb begin
        pl_sat = (in_pattern_len > 4'(MAX_PATTERN_BYTES)) ? WW'(MAX_PATTERN_BYTES)
                                                         : WW'(in_pattern_len);
        rl_sat = (in_replacement_len > 4'(MAX_REPLACEMENT_BYTES))
               ? RW'(MAX_REPLACEMENT_BYTES) : RW'(in_replacement_len);
    end

    assign wslot = SW'(in_slot);

    // Match of the scanned slot against the window
    logic [SW-1:0] sidx;
    logic          match;
    assign sidx = scan_reg[SW-1:0];
    always_comb begin
        match = (plen_reg[sidx] != '0) && (plen_reg[sidx] <= fill_reg);
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if (WW'(i) < plen_reg[sidx] && win_reg[i] != pat_reg[sidx][8*i +: 8])
                match = 1'b0;
        end
    end

    always_comb begin
        cons = hit_reg ? best_len_reg : WW'(1);
        if (cons > fill_reg)
            cons = fill_reg;
        fill_next = fill_reg - cons;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < RULE_SLOTS; s++) begin
                pat_reg[s]  <= '0;
                plen_reg[s] <= '0;
                rep_reg[s]  <= '0;
                rlen_reg[s] <= '0;
            end
            fill_reg <= '0;
            scan_reg <= '0;
            best_len_reg <= '0;
            hit_reg <= 1'b0;
            emit_reg <= '0;
        end else begin
            if (cmd.write_rule && int'(in_slot) < RULE_SLOTS) begin
                pat_reg[wslot]  <= in_pattern[PB-1:0];
                plen_reg[wslot] <= pl_sat;
                rep_reg[wslot]  <= in_replacement[RB-1:0];
                rlen_reg[wslot] <= rl_sat;
            end
            if (cmd.load_byte && fill_reg < WW'(MAX_PATTERN_BYTES)) begin
                win_reg[fill_reg[WI-1:0]] <= in_byte;
                fill_reg <= fill_reg + WW'(1);
            end
            if (cmd.scan_clear) begin
                scan_reg <= '0;
                best_len_reg <= '0;
                hit_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                scan_reg <= scan_reg + (SW+1)'(1);
                if (match && plen_reg[sidx] > best_len_reg) begin
                    best_len_reg  <= plen_reg[sidx];
                    best_rep_reg  <= rep_reg[sidx];
                    best_rlen_reg <= rlen_reg[sidx];
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.resolve) begin
                emit_reg <= '0;
                head_reg <= win_reg[0];
            end
            if (cmd.emit_step)
                emit_reg <= emit_reg + RW'(1);
            if (cmd.finish) begin
                for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
                    if (i + int'(cons) < MAX_PATTERN_BYTES)
                        win_reg[i] <= win_reg[WI'(i + int'(cons))];
                end
                fill_reg <= fill_next;
            end
        end
    end

    always_comb begin
        out_byte = hit_reg ? best_rep_reg[8*emit_reg[EI-1:0] +: 8] : head_reg;
        stat.scan_done    = (scan_reg == (SW+1)'(RULE_SLOTS - 1));
        stat.emit_none    = hit_reg && (best_rlen_reg == '0);
        stat.emit_done    = !hit_reg || (emit_reg + RW'(1) == best_rlen_reg);
        stat.window_full  = (fill_reg == WW'(MAX_PATTERN_BYTES));
        stat.window_empty = (fill_reg == '0);
    end

endmodule

[hw/rtl/lmts_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_ctrl
// Sequencer: accept, scan slots, emit bytes, shift window, repeat on flush.
// ----------------------------------------------------------------------------
module lmts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 op,
    input  logic                 eot,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 flush_active,
    output logic                 flush_done,
    output lmts_pkg::lmts_cmd_t  cmd,
    input  lmts_pkg::lmts_stat_t stat
);
    import lmts_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_RES   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       flush_reg, flush_next;
    logic       acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_EMIT);
    assign flush_active = flush_reg;

    always_comb begin
        cmd = '0;
        flush_done = 1'b0;
        state_next = state_reg;
        flush_next = flush_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (op == OP_WRITE) begin
                        cmd.write_rule = 1'b1;
                    end else begin
                        cmd.load_byte = 1'b1;
                        flush_next = eot;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                cmd.scan_clear = 1'b1;
                if (stat.window_empty || (!flush_reg && !stat.window_full)) begin
                    // flush ends once the window has drained
                    flush_done = flush_reg && stat.window_empty;
                    flush_next = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = ST_RES;
            end
            ST_RES: begin
                cmd.resolve = 1'b1;
                state_next = stat.emit_none ? ST_FIN : ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    cmd.emit_step = 1'b1;
                    if (stat.emit_done)
                        state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_CHECK;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

endmodule

[hw/rtl/longest_match_text_substituter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_match_text_substituter_core
// Longest-match multi-pattern text substitution over a byte stream.
// ----------------------------------------------------------------------------
// Use: s_ transfers carry either a rule write (s_tuser = 1) or a text byte
// (s_tuser = 0, s_tlast = end of text). m_ transfers carry rewritten bytes;
// m_tlast marks the final byte of a text.
// Each resolved position scans the rule table one slot per cycle,
// then emits 0..MAX_REPLACEMENT_BYTES bytes, one per cycle the receiver
// takes. A text byte that only fills the window returns to idle without a
// scan; one that resolves is scanned and emitted before the next is accepted.
// A flush repeats scan and emit per pending position. A rule write leaves
// the sequencer idle.
// Output bytes are staged in a one-entry output register behind the
// sequencer. During a flush the staged byte is held until the next byte
// of the flush is ready or the flush ends, which sets m_tlast.
// A stall on m_tready stalls the sequencer; no data is lost.
// Reset clears all rule slots (disabled) and empties the window.
// ----------------------------------------------------------------------------
module longest_match_text_substituter_core #(
    parameter int RULE_SLOTS = 16,
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: text_byte[7:0], rule_slot[11:8], pattern_bits[75:12],
    // pattern_length[79:76], replacement_bits[143:80], replacement_length[147:144]
    input  logic [151:0] s_tdata,
    input  logic         s_tuser,   // operation
    input  logic         s_tlast,   // end_of_text
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // out_byte
    output logic         m_tlast    // out_last
);
    import lmts_pkg::*;

    lmts_cmd_t  cmd;
    lmts_stat_t stat;
    logic       core_valid, core_ready, core_flush, flush_done;
    logic [7:0] core_byte;

    lmts_datapath #(
        .RULE_SLOTS(RULE_SLOTS),
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
        .MAX_REPLACEMENT_BYTES(MAX_REPLACEMENT_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_byte(s_tdata[7:0]), .in_slot(s_tdata[11:8]),
        .in_pattern(s_tdata[75:12]), .in_pattern_len(s_tdata[79:76]),
        .in_replacement(s_tdata[143:80]), .in_replacement_len(s_tdata[147:144]),
        .out_byte(core_byte)
    );

    lmts_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .op(s_tuser), .eot(s_tlast),
        .m_tvalid(core_valid), .m_tready(core_ready),
        .flush_active(core_flush), .flush_done(flush_done),
        .cmd(cmd), .stat(stat)
    );

    // Output register. A byte taken during a flush waits: if another byte of
    // the flush follows it goes out plain, if the flush ends it carries tlast.
    // Bytes outside a flush go out at once.
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg, hold_byte_next;
    logic       hold_wait_reg, hold_wait_next;
    logic       hold_last_reg, hold_last_next;

    // core_valid stays up until its byte is taken, so tvalid cannot drop
    assign m_tvalid = hold_valid_reg && (!hold_wait_reg || core_valid);
    assign m_tdata  = hold_byte_reg;
    assign m_tlast  = m_tvalid && hold_last_reg;
    // accept a core byte when the register is empty or being drained
    assign core_ready = !hold_valid_reg || (m_tvalid && m_tready);

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_wait_next  = hold_wait_reg;
        hold_last_next  = hold_last_reg;
        if (m_tvalid && m_tready) begin
            hold_valid_next = 1'b0;
            hold_last_next  = 1'b0;
        end
        if (core_valid && core_ready) begin
            hold_valid_next = 1'b1;
            hold_byte_next  = core_byte;
            hold_wait_next  = core_flush;
            hold_last_next  = 1'b0;
        end
        // empty flush tail: a waiting byte becomes the last one
        if (flush_done && hold_valid_reg && hold_wait_reg) begin
            hold_wait_next = 1'b0;
            hold_last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            hold_wait_reg  <= 1'b0;
            hold_last_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            hold_byte_reg  <= hold_byte_next;
            hold_wait_reg  <= hold_wait_next;
            hold_last_reg  <= hold_last_next;
        end
    end

endmodule

[hw/rtl/lmts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_checker
// Port-level checks for the longest-match substituter.
// ----------------------------------------------------------------------------
`include "longest_match_text_substituter_core_defines.svh"
module lmts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    `LMTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "output changed while stalled")
    `LMTS_ASSERT_IMPL(a_last_valid, aclk, aresetn, m_tlast, m_tvalid,
        "tlast without tvalid")
    `LMTS_ASSERT_NEXT(a_reset_idle, aclk, 1'b1, !aresetn, !m_tvalid,
        "output valid after reset")
    `LMTS_ASSERT_NEXT(a_text_busy, aclk, aresetn, s_tvalid && s_tready && !s_tuser,
        !s_tready, "input ready right after a text transfer")
endmodule

bind longest_match_text_substituter_core lmts_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
